[rtl/dual_gnss_position_heading_top_assert.svh]
// Assertion macros for the dual GNSS position and heading block
`ifndef DUAL_GNSS_POSITION_HEADING_TOP_ASSERT_SVH
`define DUAL_GNSS_POSITION_HEADING_TOP_ASSERT_SVH
`ifndef SYNTH
`define DGPH_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("dgph");
`define DGPH_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("dgph");
`else
`define DGPH_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define DGPH_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

[rtl/dgph_pkg.sv]
// ----------------------------------------------------------------------------
// dgph_pkg
// Constants, CORDIC angle table and the cell interface type.
// ----------------------------------------------------------------------------
`default_nettype none
package dgph_pkg;
  localparam int unsigned MaxTab = 32;
  localparam logic signed [63:0] Quarter = 64'sd900000000;
  localparam logic signed [63:0] Half = 64'sd1800000000;
  localparam logic signed [63:0] Full = 64'sd3600000000;
  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam logic [23:0] CmReset = 24'd11113900;
  localparam logic [0:0] RegCm = 1'b0;

  // one value moving through the cell chain
  typedef struct packed {
    logic              vec;   // vectoring (heading) or rotation (cosine)
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_t;

  function automatic logic signed [63:0] atan_deg7(input logic [4:0] i);
    logic signed [63:0] r;
    begin
      case (i)
        5'd0: r = 450000000;  5'd1: r = 265650512; 5'd2: r = 140362435;
        5'd3: r = 71250163;   5'd4: r = 35763344;  5'd5: r = 17899106;
        5'd6: r = 8951737;    5'd7: r = 4476142;   5'd8: r = 2238105;
        5'd9: r = 1119057;    5'd10: r = 559529;   5'd11: r = 279765;
        5'd12: r = 139882;    5'd13: r = 69941;    5'd14: r = 34971;
        5'd15: r = 17485;     5'd16: r = 8743;     5'd17: r = 4371;
        5'd18: r = 2186;      5'd19: r = 1093;     5'd20: r = 546;
        5'd21: r = 273;       5'd22: r = 137;      5'd23: r = 68;
        5'd24: r = 34;        5'd25: r = 17;       5'd26: r = 9;
        5'd27: r = 4;         5'd28: r = 2;        5'd29: r = 1;
        5'd30: r = 1;         default: r = 0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

[rtl/dual_gnss_position_heading_top.sv]
// Each request runs S_MUL, S_RND, S_SUM, S_HEAD0, S_HEADW and S_FIN; the first one
// runs the cosine pass (S_COS0, S_COSW) before them; one request at a time.
// The cell chain of the CORDIC and the shared 64-bit multiplier set the time taken.
// Reset (rst_n, synchronous) clears the origin, zero midpoint and register to
// its default; no clearing pass.
`default_nettype none
module dual_gnss_position_heading_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // mid_north, mid_east, heading[79:64], a_north, a_east, b_north, b_east
  output logic [207:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import dgph_pkg::*;
  `include "dual_gnss_position_heading_top_assert.svh"
  localparam int unsigned Steps = (CORDIC_STEPS > MaxTab) ? MaxTab : CORDIC_STEPS;

  typedef enum logic [3:0] {S_IDLE, S_COS0, S_COSW, S_MUL, S_RND, S_SUM, S_HEAD0,
                            S_HEADW, S_FIN, S_OUT} state_t;
  state_t st_r;
  logic [23:0] cm_r, scale_r;
  logic started_r, out_valid_r;
  logic signed [30:0] olat_r;
  logic signed [31:0] olon_r;
  logic signed [63:0] zn_r, ze_r;
  logic signed [30:0] la_r, lb_r;
  logic signed [31:0] ona_r, onb_r;
  logic signed [63:0] p_r [4];
  logic signed [63:0] q_r [4];
  logic [2:0] mi_r;
  logic [5:0] cnt_r;
  logic [207:0] out_r;
  cordic_t cin_r, cout;
  logic head_zero_r;

  dgph_chain #(.Steps(Steps)) u_chain (.clk(clk), .d_in(cin_r), .d_out(cout));

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {8'd0, cm_r};
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r;

  function automatic logic signed [63:0] rdiv7(input logic signed [63:0] v);
    logic [63:0] m;
    begin
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + 64'd5000000) / 64'd10000000;
      return v[63] ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic logic [31:0] sat(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    end
  endfunction

  logic signed [63:0] mul_a, mul_b, mul_p;
  logic signed [63:0] an, bn, ae, be, mn, me, dn, de, hz, ht;
  logic signed [63:0] cx;
  logic [31:0] dmul;
  always_comb begin
    // one shared multiplier; pick the operands for this step
    case (mi_r[1:0])
      2'd0: begin mul_a = {40'd0, cm_r}; mul_b = 64'(la_r) - 64'(olat_r); end
      2'd1: begin mul_a = {40'd0, cm_r}; mul_b = 64'(lb_r) - 64'(olat_r); end
      2'd2: begin mul_a = {40'd0, scale_r}; mul_b = 64'(ona_r) - 64'(olon_r); end
      default: begin mul_a = {40'd0, scale_r}; mul_b = 64'(onb_r) - 64'(olon_r); end
    endcase
    mul_p = mul_a * mul_b;
    an = q_r[0]; bn = q_r[1]; ae = q_r[2]; be = q_r[3];
    mn = (an + bn) >>> 1;
    me = (ae + be) >>> 1;
    dn = an - bn;
    de = ae - be;
    cx = cout.x;
    hz = cout.z + Half;
    ht = hz * 64'sd65536 + Half;
    dmul = 32'((ht - (ht < 0 ? Full - 1 : 64'sd0)) / Full);
  end

  logic signed [63:0] zlat;
  always_comb begin
    zlat = 64'(la_r);
    if (zlat > Quarter) zlat = Quarter;
    if (zlat < -Quarter) zlat = -Quarter;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cm_r <= CmReset;
      started_r <= 1'b0;
      out_valid_r <= 1'b0;
      olat_r <= '0; olon_r <= '0; scale_r <= '0; zn_r <= '0; ze_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == {RegCm, 1'b0})
        cm_r <= cfg_pwdata[23:0];
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          la_r <= in_tdata[30:0]; ona_r <= in_tdata[62:31];
          lb_r <= in_tdata[93:63]; onb_r <= in_tdata[125:94];
          mi_r <= '0;
          st_r <= started_r ? S_MUL : S_COS0;
        end
        S_COS0: begin
          olat_r <= la_r; olon_r <= ona_r;
          cin_r.vec <= 1'b0;
          cin_r.x <= $signed(({40'd0, cm_r} * {32'd0, GainQ30}) >> 14);
          cin_r.y <= '0; cin_r.z <= zlat;
          cnt_r <= '0; st_r <= S_COSW;
        end
        S_COSW: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(Steps)) begin
            if (cx <= 0) scale_r <= '0;
            else if (((cx + 64'sd32768) >>> 16) > 64'sd16777215) scale_r <= 24'hffffff;
            else scale_r <= 24'(((cx + 64'sd32768) >>> 16));
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_r[mi_r[1:0]] <= mul_p;
          mi_r <= mi_r + 3'd1;
          if (mi_r == 3'd3) begin mi_r <= '0; st_r <= S_RND; end
        end
        S_RND: begin
          q_r[mi_r[1:0]] <= rdiv7(p_r[mi_r[1:0]]);
          mi_r <= mi_r + 3'd1;
          if (mi_r == 3'd3) st_r <= S_SUM;
        end
        S_SUM: begin
          if (!started_r) begin
            zn_r <= $signed(sat(mn)); ze_r <= $signed(sat(me));
            started_r <= 1'b1;
          end
          st_r <= S_HEAD0;
        end
        S_HEAD0: begin
          head_zero_r <= (dn == 0) && (de == 0);
          cin_r.vec <= 1'b1;
          if (dn < 0) begin
            if (de >= 0) begin
              cin_r.x <= de <<< 20; cin_r.y <= -(dn <<< 20); cin_r.z <= Quarter;
            end else begin
              cin_r.x <= -(de <<< 20); cin_r.y <= dn <<< 20; cin_r.z <= -Quarter;
            end
          end else begin
            cin_r.x <= dn <<< 20; cin_r.y <= de <<< 20; cin_r.z <= '0;
          end
          cnt_r <= '0; st_r <= S_HEADW;
        end
        S_HEADW: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(Steps)) st_r <= S_FIN;
        end
        S_FIN: begin
          out_r <= {sat(be - ze_r), sat(bn - zn_r), sat(ae - ze_r), sat(an - zn_r),
                    head_zero_r ? 16'd32768 : dmul[15:0],
                    sat(me - ze_r), sat(mn - zn_r)};
          out_valid_r <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_valid_r <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `DGPH_ASSERT_IMPL(a_busy, clk, rst_n, out_tvalid, !in_tready)
  `DGPH_ASSERT_NEXT(a_take, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `DGPH_ASSERT_NEXT(a_done, clk, rst_n, out_tvalid && out_tready, in_tready)
endmodule
`default_nettype wire

[rtl/dgph_cell.sv]
// ----------------------------------------------------------------------------
// dgph_cell
// One CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module dgph_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic              clk,
  input  wire dgph_pkg::cordic_t d_in,
  output dgph_pkg::cordic_t      d_out
);
  import dgph_pkg::*;
  cordic_t res_nxt;
  logic dir;
  logic signed [63:0] ang;
  assign ang = atan_deg7(5'(Idx));
  always_comb begin
    res_nxt = d_in;
    // vectoring turns clockwise while y is non-negative
    dir = d_in.vec ? (d_in.y >= 0) : (d_in.z < 0);
    if (dir) begin
      res_nxt.x = d_in.x + (d_in.y >>> Idx);
      res_nxt.y = d_in.y - (d_in.x >>> Idx);
      res_nxt.z = d_in.vec ? d_in.z + ang : d_in.z + ang;
    end else begin
      res_nxt.x = d_in.x - (d_in.y >>> Idx);
      res_nxt.y = d_in.y + (d_in.x >>> Idx);
      res_nxt.z = d_in.z - ang;
    end
  end
  always_ff @(posedge clk) begin
    d_out <= res_nxt;
  end
endmodule
`default_nettype wire

[rtl/dgph_chain.sv]
// ----------------------------------------------------------------------------
// dgph_chain
// Row of CORDIC cells; the data enters at cell 0 and leaves from the last cell.
// ----------------------------------------------------------------------------
`default_nettype none
module dgph_chain #(
  parameter int unsigned Steps = 16
) (
  input  wire logic              clk,
  input  wire dgph_pkg::cordic_t d_in,
  output dgph_pkg::cordic_t      d_out
);
  import dgph_pkg::*;
  cordic_t tap [Steps+1];
  assign tap[0] = d_in;
  for (genvar g = 0; g < Steps; g++) begin : g_cell
    dgph_cell #(.Idx(g)) u_cell (.clk(clk), .d_in(tap[g]), .d_out(tap[g+1]));
  end
  assign d_out = tap[Steps];
endmodule
`default_nettype wire
